>>> sv/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/i2cstm_pkg.sv
// Types and constants of the I2C sensor transaction master.
package i2cstm_pkg;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_START_A = 5'd1,
    ST_START_B = 5'd2,
    ST_TX_LO1  = 5'd3,
    ST_TX_HI   = 5'd4,
    ST_TX_LO2  = 5'd5,
    ST_TX_TAIL = 5'd6,
    ST_AK_LO   = 5'd7,
    ST_AK_HI   = 5'd8,
    ST_AK_POLL = 5'd9,
    ST_RX_LO   = 5'd10,
    ST_RX_HI   = 5'd11,
    ST_RA_LO   = 5'd12,
    ST_RA_HI   = 5'd13,
    ST_SP_LO   = 5'd14,
    ST_SP_HI   = 5'd15,
    ST_WAIT    = 5'd16
  } seq_state_e;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_PHASE      = 2'd1,
    CFG_ACK_TMO    = 2'd2,
    CFG_POST_WRITE = 2'd3
  } cfg_index_e;

  localparam logic [6:0]  DevAddrRst   = 7'd88;
  localparam logic [15:0] PhaseRst     = 16'd20;
  localparam logic [7:0]  AckTmoRst    = 8'd250;
  localparam logic [19:0] PostWriteRst = 20'd100000;

  // Byte index (after increment) of the checksum byte in a read, and of the NACKed byte.
  localparam logic [2:0] ChecksumByte = 3'd3;
  localparam logic [2:0] LastByte     = 3'd5;
  localparam logic [3:0] LastBit      = 4'd7;

endpackage

>>> sv/i2c_sensor_transaction_master_core.sv
// I2C sensor transaction master: tick-driven bus sequencer with a registered result.
// The result of a tick is presented in the cycle after the tick is accepted.
// Throughput: one tick per clock cycle unless the result side stalls; the sequencer
// state step is one pass of short logic between the state and result registers.
// Reset: asynchronous, active low; sequencer idle, counters and data word zero,
// configuration registers at their default values, no result pending.
`include "assert_macros.svh"

module i2c_sensor_transaction_master_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  cmd_first_byte_i,
  input  logic [7:0]  cmd_second_byte_i,
  input  logic        sda_sample_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        sda_driving_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        ack_error_o,
  output logic [31:0] read_word_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  // Configuration registers.
  logic [6:0]  dev_addr_q;
  logic [15:0] phase_len_q;
  logic [7:0]  ack_tmo_q;
  logic [19:0] post_write_q;

  // Sequencer state.
  i2cstm_pkg::seq_state_e state_q, state_d;
  logic [15:0] phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  tmo_q, tmo_d;
  logic [19:0] wait_q, wait_d;
  logic [31:0] word_q, word_d;
  logic [15:0] pend_q, pend_d;
  logic        rmode_q, rmode_d;
  logic        err_q, err_d;

  // State seen by this tick after a command is taken; drives the line levels.
  i2cstm_pkg::seq_state_e cur_state;
  logic        cur_bit7;
  logic        cur_nack;
  logic        done_d;
  logic        ack_err_d;

  // Line levels of this tick.
  logic        scl_d, sda_d, drv_d, busy_d;

  // Result register.
  logic        out_valid_q;
  logic        scl_q, sda_q, drv_q, busy_q, done_q, ack_err_q;
  logic [31:0] rword_q;

  logic        in_fire;
  logic        cfg_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Configuration writes take effect at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= i2cstm_pkg::DevAddrRst;
      phase_len_q  <= i2cstm_pkg::PhaseRst;
      ack_tmo_q    <= i2cstm_pkg::AckTmoRst;
      post_write_q <= i2cstm_pkg::PostWriteRst;
    end else if (cfg_fire) begin
      unique case (i2cstm_pkg::cfg_index_e'(cfg_index_i))
        i2cstm_pkg::CFG_DEV_ADDR:   dev_addr_q   <= cfg_data_i[6:0];
        i2cstm_pkg::CFG_PHASE:      phase_len_q  <= cfg_data_i[15:0];
        i2cstm_pkg::CFG_ACK_TMO:    ack_tmo_q    <= cfg_data_i[7:0];
        i2cstm_pkg::CFG_POST_WRITE: post_write_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and datapath for one tick.
  always_comb begin : next_state
    logic        half;
    logic [15:0] plen;
    logic        pdone;
    logic [15:0] pnext;

    state_d   = state_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    tmo_d     = tmo_q;
    wait_d    = wait_q;
    word_d    = word_q;
    pend_d    = pend_q;
    rmode_d   = rmode_q;
    err_d     = err_q;
    done_d    = 1'b0;
    ack_err_d = 1'b0;

    // A command is taken only while idle; the taking tick is the first START tick.
    if (state_q == i2cstm_pkg::ST_IDLE &&
        (func_i == i2cstm_pkg::FUNC_WRITE || func_i == i2cstm_pkg::FUNC_READ)) begin
      rmode_d = (func_i == i2cstm_pkg::FUNC_READ);
      pend_d  = {cmd_first_byte_i, cmd_second_byte_i};
      shift_d = {dev_addr_q, rmode_d};
      byte_d  = '0;
      bit_d   = '0;
      phase_d = '0;
      tmo_d   = '0;
      err_d   = 1'b0;
      state_d = i2cstm_pkg::ST_START_A;
    end

    cur_state = state_d;
    cur_bit7  = shift_d[7];
    cur_nack  = (byte_d >= i2cstm_pkg::LastByte);

    // Phase timing: the two phases ahead of the acknowledge poll are half length.
    half  = (state_d == i2cstm_pkg::ST_AK_LO) || (state_d == i2cstm_pkg::ST_AK_HI);
    plen  = half ? {1'b0, phase_len_q[15:1]} : phase_len_q;
    if (plen == '0) begin
      plen = 16'd1;
    end
    pdone = ({1'b0, phase_d} + 17'd1) >= {1'b0, plen};
    pnext = pdone ? '0 : phase_d + 16'd1;

    unique case (state_d)
      i2cstm_pkg::ST_IDLE: ;
      i2cstm_pkg::ST_START_A: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_START_B;
      end
      i2cstm_pkg::ST_START_B: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_TX_LO1;
      end
      i2cstm_pkg::ST_TX_LO1: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_TX_HI;
      end
      i2cstm_pkg::ST_TX_HI: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_TX_LO2;
      end
      i2cstm_pkg::ST_TX_LO2: begin
        phase_d = pnext;
        if (pdone) begin
          if (bit_d >= i2cstm_pkg::LastBit) begin
            state_d = i2cstm_pkg::ST_TX_TAIL;
          end else begin
            shift_d = {shift_d[6:0], 1'b0};
            bit_d   = bit_d + 4'd1;
            state_d = i2cstm_pkg::ST_TX_LO1;
          end
        end
      end
      i2cstm_pkg::ST_TX_TAIL: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_AK_LO;
      end
      i2cstm_pkg::ST_AK_LO: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_AK_HI;
      end
      i2cstm_pkg::ST_AK_HI: begin
        phase_d = pnext;
        if (pdone) begin
          tmo_d   = '0;
          state_d = i2cstm_pkg::ST_AK_POLL;
        end
      end
      i2cstm_pkg::ST_AK_POLL: begin
        phase_d = '0;
        if (!sda_sample_i) begin
          byte_d = byte_d + 3'd1;
          bit_d  = '0;
          if (rmode_d) begin
            shift_d = '0;
            state_d = i2cstm_pkg::ST_RX_LO;
          end else if (byte_d == 3'd1) begin
            shift_d = pend_d[15:8];
            state_d = i2cstm_pkg::ST_TX_LO1;
          end else if (byte_d == 3'd2) begin
            shift_d = pend_d[7:0];
            state_d = i2cstm_pkg::ST_TX_LO1;
          end else begin
            state_d = i2cstm_pkg::ST_SP_LO;
          end
        end else if (tmo_d == ack_tmo_q) begin
          // Acknowledge timed out: stop and end with the error flag.
          err_d   = 1'b1;
          state_d = i2cstm_pkg::ST_SP_LO;
        end else begin
          tmo_d = tmo_d + 8'd1;
        end
      end
      i2cstm_pkg::ST_RX_LO: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_RX_HI;
      end
      i2cstm_pkg::ST_RX_HI: begin
        // Sample on the first tick of the high phase.
        if (phase_d == '0) shift_d = {shift_d[6:0], sda_sample_i};
        phase_d = pnext;
        if (pdone) begin
          if (bit_d >= i2cstm_pkg::LastBit) begin
            if (byte_d != i2cstm_pkg::ChecksumByte) word_d = {word_d[23:0], shift_d};
            state_d = i2cstm_pkg::ST_RA_LO;
          end else begin
            bit_d   = bit_d + 4'd1;
            state_d = i2cstm_pkg::ST_RX_LO;
          end
        end
      end
      i2cstm_pkg::ST_RA_LO: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_RA_HI;
      end
      i2cstm_pkg::ST_RA_HI: begin
        phase_d = pnext;
        if (pdone) begin
          if (byte_d >= i2cstm_pkg::LastByte) begin
            state_d = i2cstm_pkg::ST_SP_LO;
          end else begin
            byte_d  = byte_d + 3'd1;
            bit_d   = '0;
            shift_d = '0;
            state_d = i2cstm_pkg::ST_RX_LO;
          end
        end
      end
      i2cstm_pkg::ST_SP_LO: begin
        phase_d = pnext;
        if (pdone) state_d = i2cstm_pkg::ST_SP_HI;
      end
      i2cstm_pkg::ST_SP_HI: begin
        phase_d = pnext;
        if (pdone) begin
          done_d    = 1'b1;
          ack_err_d = err_d;
          if (!rmode_d && !err_d && post_write_q != '0) begin
            wait_d  = '0;
            state_d = i2cstm_pkg::ST_WAIT;
          end else begin
            state_d = i2cstm_pkg::ST_IDLE;
          end
        end
      end
      i2cstm_pkg::ST_WAIT: begin
        if (({1'b0, wait_d} + 21'd1) >= {1'b0, post_write_q}) begin
          wait_d  = '0;
          state_d = i2cstm_pkg::ST_IDLE;
        end else begin
          wait_d = wait_d + 20'd1;
        end
      end
      default: state_d = i2cstm_pkg::ST_IDLE;
    endcase
  end

  // Bus levels of this tick, from the state the tick runs in.
  always_comb begin : line_levels
    scl_d  = 1'b1;
    sda_d  = 1'b1;
    drv_d  = 1'b1;
    busy_d = (cur_state != i2cstm_pkg::ST_IDLE);
    unique case (cur_state)
      i2cstm_pkg::ST_START_B: sda_d = 1'b0;
      i2cstm_pkg::ST_TX_LO1, i2cstm_pkg::ST_TX_LO2, i2cstm_pkg::ST_TX_TAIL: begin
        scl_d = 1'b0;
        sda_d = cur_bit7;
      end
      i2cstm_pkg::ST_TX_HI: sda_d = cur_bit7;
      i2cstm_pkg::ST_AK_LO, i2cstm_pkg::ST_RX_LO: begin
        scl_d = 1'b0;
        drv_d = 1'b0;
      end
      i2cstm_pkg::ST_AK_HI, i2cstm_pkg::ST_AK_POLL, i2cstm_pkg::ST_RX_HI: drv_d = 1'b0;
      i2cstm_pkg::ST_RA_LO: begin
        scl_d = 1'b0;
        sda_d = cur_nack;
      end
      i2cstm_pkg::ST_RA_HI: sda_d = cur_nack;
      i2cstm_pkg::ST_SP_LO: begin
        scl_d = 1'b0;
        sda_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Advance the sequencer on every accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2cstm_pkg::ST_IDLE;
      phase_q <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      tmo_q   <= '0;
      wait_q  <= '0;
      word_q  <= '0;
      pend_q  <= '0;
      rmode_q <= 1'b0;
      err_q   <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      tmo_q   <= tmo_d;
      wait_q  <= wait_d;
      word_q  <= word_d;
      pend_q  <= pend_d;
      rmode_q <= rmode_d;
      err_q   <= err_d;
    end
  end

  // Result register: hold a result until its transfer, refill on every accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drv_q     <= drv_d;
      busy_q    <= busy_d;
      done_q    <= done_d;
      ack_err_q <= ack_err_d;
      rword_q   <= word_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = scl_q;
  assign sda_level_o   = sda_q;
  assign sda_driving_o = drv_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign ack_error_o   = ack_err_q;
  assign read_word_o   = rword_q;

  `ASSERT_IMPLIES(a_done_while_busy, clk_i, rst_ni, out_valid_o && done_res_o, busy_res_o)
  `ASSERT_IMPLIES(a_err_with_done, clk_i, rst_ni, out_valid_o && ack_error_o, done_res_o)
  `ASSERT_IMPLIES(a_idle_phase_clear, clk_i, rst_ni, state_q == i2cstm_pkg::ST_IDLE, phase_q == '0)
  `ASSERT_NEXT(a_wait_exit, clk_i, rst_ni, in_fire && state_q == i2cstm_pkg::ST_WAIT, state_q == i2cstm_pkg::ST_WAIT || state_q == i2cstm_pkg::ST_IDLE)

endmodule

>>> sim/tb_i2c_sensor_transaction_master_core.sv
// Testbench for the I2C sensor transaction master core: random bus ticks checked by a predictor.
`timescale 1ns / 100ps

typedef struct {
  i2cstm_pkg::func_e func;
  logic [7:0]        first;
  logic [7:0]        second;
  logic              sda;
} bus_tick_t;

typedef struct {
  logic        scl;
  logic        sda;
  logic        drive;
  logic        busy;
  logic        done;
  logic        err;
  logic [31:0] word;
} bus_view_t;

// Predicts the bus levels of every tick and holds them until the block presents them.
class sensor_bus_scoreboard;
  logic [6:0]  dev_addr;
  logic [15:0] phase_ticks;
  logic [7:0]  ack_limit;
  logic [19:0] post_ticks;

  i2cstm_pkg::seq_state_e seq;
  logic [15:0] phase_cnt;
  logic [3:0]  bit_cnt;
  logic [2:0]  byte_cnt;
  logic [7:0]  shreg;
  logic [7:0]  tmo_cnt;
  logic [19:0] wait_cnt;
  logic [31:0] word;
  logic [15:0] cmd_pair;
  logic        rd;
  logic        err_seen;

  bus_view_t   levels_q[$];
  int          mismatches;
  int          results_seen;

  function new();
    dev_addr     = i2cstm_pkg::DevAddrRst;
    phase_ticks  = i2cstm_pkg::PhaseRst;
    ack_limit    = i2cstm_pkg::AckTmoRst;
    post_ticks   = i2cstm_pkg::PostWriteRst;
    seq          = i2cstm_pkg::ST_IDLE;
    phase_cnt    = '0;
    bit_cnt      = '0;
    byte_cnt     = '0;
    shreg        = '0;
    tmo_cnt      = '0;
    wait_cnt     = '0;
    word         = '0;
    cmd_pair     = '0;
    rd           = 1'b0;
    err_seen     = 1'b0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function void set_reg(i2cstm_pkg::cfg_index_e idx, logic [19:0] value);
    case (idx)
      i2cstm_pkg::CFG_DEV_ADDR:   dev_addr = value[6:0];
      i2cstm_pkg::CFG_PHASE:      phase_ticks = value[15:0];
      i2cstm_pkg::CFG_ACK_TMO:    ack_limit = value[7:0];
      i2cstm_pkg::CFG_POST_WRITE: post_ticks = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return levels_q.size();
  endfunction

  // Advance the phase counter; a phase of zero ticks lasts one tick.
  function bit phase_done(bit half);
    logic [15:0] len;
    len = half ? (phase_ticks >> 1) : phase_ticks;
    if (len == 16'd0) len = 16'd1;
    if (int'(phase_cnt) + 1 >= int'(len)) begin
      phase_cnt = '0;
      return 1'b1;
    end
    phase_cnt = phase_cnt + 16'd1;
    return 1'b0;
  endfunction

  function void note_tick(bus_tick_t t);
    bus_view_t e;
    logic      b7;
    e = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0, done: 1'b0, err: 1'b0, word: '0};
    // A command on an idle tick also counts as the first START tick.
    if (seq == i2cstm_pkg::ST_IDLE &&
        (t.func == i2cstm_pkg::FUNC_WRITE || t.func == i2cstm_pkg::FUNC_READ)) begin
      rd       = (t.func == i2cstm_pkg::FUNC_READ);
      cmd_pair = {t.first, t.second};
      shreg    = {dev_addr, rd};
      byte_cnt = '0;
      bit_cnt  = '0;
      phase_cnt = '0;
      tmo_cnt  = '0;
      err_seen = 1'b0;
      seq      = i2cstm_pkg::ST_START_A;
    end
    e.busy = (seq != i2cstm_pkg::ST_IDLE);
    b7 = shreg[7];

    case (seq)
      i2cstm_pkg::ST_IDLE: ;
      i2cstm_pkg::ST_START_A: if (phase_done(1'b0)) seq = i2cstm_pkg::ST_START_B;
      i2cstm_pkg::ST_START_B: begin
        e.sda = 1'b0;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_TX_LO1;
      end
      i2cstm_pkg::ST_TX_LO1: begin
        e.scl = 1'b0;
        e.sda = b7;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_TX_HI;
      end
      i2cstm_pkg::ST_TX_HI: begin
        e.sda = b7;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_TX_LO2;
      end
      i2cstm_pkg::ST_TX_LO2: begin
        e.scl = 1'b0;
        e.sda = b7;
        if (phase_done(1'b0)) begin
          if (bit_cnt >= i2cstm_pkg::LastBit) begin
            seq = i2cstm_pkg::ST_TX_TAIL;
          end else begin
            shreg   = shreg << 1;
            bit_cnt = bit_cnt + 4'd1;
            seq     = i2cstm_pkg::ST_TX_LO1;
          end
        end
      end
      i2cstm_pkg::ST_TX_TAIL: begin
        e.scl = 1'b0;
        e.sda = b7;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_AK_LO;
      end
      i2cstm_pkg::ST_AK_LO: begin
        e.scl   = 1'b0;
        e.drive = 1'b0;
        if (phase_done(1'b1)) seq = i2cstm_pkg::ST_AK_HI;
      end
      i2cstm_pkg::ST_AK_HI: begin
        e.drive = 1'b0;
        if (phase_done(1'b1)) begin
          tmo_cnt = '0;
          seq     = i2cstm_pkg::ST_AK_POLL;
        end
      end
      i2cstm_pkg::ST_AK_POLL: begin
        e.drive   = 1'b0;
        phase_cnt = '0;
        if (!t.sda) begin
          byte_cnt = byte_cnt + 3'd1;
          bit_cnt  = '0;
          if (rd) begin
            shreg = '0;
            seq   = i2cstm_pkg::ST_RX_LO;
          end else if (byte_cnt == 3'd1) begin
            shreg = cmd_pair[15:8];
            seq   = i2cstm_pkg::ST_TX_LO1;
          end else if (byte_cnt == 3'd2) begin
            shreg = cmd_pair[7:0];
            seq   = i2cstm_pkg::ST_TX_LO1;
          end else begin
            seq = i2cstm_pkg::ST_SP_LO;
          end
        end else if (tmo_cnt == ack_limit) begin
          err_seen = 1'b1;
          seq      = i2cstm_pkg::ST_SP_LO;
        end else begin
          tmo_cnt = tmo_cnt + 8'd1;
        end
      end
      i2cstm_pkg::ST_RX_LO: begin
        e.scl   = 1'b0;
        e.drive = 1'b0;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_RX_HI;
      end
      i2cstm_pkg::ST_RX_HI: begin
        e.drive = 1'b0;
        if (phase_cnt == 16'd0) shreg = {shreg[6:0], t.sda};
        if (phase_done(1'b0)) begin
          if (bit_cnt >= i2cstm_pkg::LastBit) begin
            // the checksum byte never reaches the data word
            if (byte_cnt != i2cstm_pkg::ChecksumByte) word = {word[23:0], shreg};
            seq = i2cstm_pkg::ST_RA_LO;
          end else begin
            bit_cnt = bit_cnt + 4'd1;
            seq     = i2cstm_pkg::ST_RX_LO;
          end
        end
      end
      i2cstm_pkg::ST_RA_LO: begin
        e.scl = 1'b0;
        e.sda = (byte_cnt >= i2cstm_pkg::LastByte);
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_RA_HI;
      end
      i2cstm_pkg::ST_RA_HI: begin
        e.sda = (byte_cnt >= i2cstm_pkg::LastByte);
        if (phase_done(1'b0)) begin
          if (byte_cnt >= i2cstm_pkg::LastByte) begin
            seq = i2cstm_pkg::ST_SP_LO;
          end else begin
            byte_cnt = byte_cnt + 3'd1;
            bit_cnt  = '0;
            shreg    = '0;
            seq      = i2cstm_pkg::ST_RX_LO;
          end
        end
      end
      i2cstm_pkg::ST_SP_LO: begin
        e.scl = 1'b0;
        e.sda = 1'b0;
        if (phase_done(1'b0)) seq = i2cstm_pkg::ST_SP_HI;
      end
      i2cstm_pkg::ST_SP_HI: begin
        if (phase_done(1'b0)) begin
          e.done = 1'b1;
          e.err  = err_seen;
          if (!rd && !err_seen && post_ticks != 20'd0) begin
            wait_cnt = '0;
            seq      = i2cstm_pkg::ST_WAIT;
          end else begin
            seq = i2cstm_pkg::ST_IDLE;
          end
        end
      end
      i2cstm_pkg::ST_WAIT: begin
        if (int'(wait_cnt) + 1 >= int'(post_ticks)) begin
          wait_cnt = '0;
          seq      = i2cstm_pkg::ST_IDLE;
        end else begin
          wait_cnt = wait_cnt + 20'd1;
        end
      end
      default: seq = i2cstm_pkg::ST_IDLE;
    endcase

    e.word = word;
    levels_q.push_back(e);
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s got 0x%0h expected 0x%0h", results_seen, name, got, want));
    end
  endtask

  task check_result(bus_view_t got);
    bus_view_t w;
    if (levels_q.size() == 0) begin
      report($sformatf("result %0d arrived with no tick outstanding", results_seen));
      results_seen++;
      return;
    end
    w = levels_q.pop_front();
    compare_field("scl_level", 32'(got.scl), 32'(w.scl));
    compare_field("sda_level", 32'(got.sda), 32'(w.sda));
    compare_field("sda_driving", 32'(got.drive), 32'(w.drive));
    compare_field("busy_res", 32'(got.busy), 32'(w.busy));
    compare_field("done_res", 32'(got.done), 32'(w.done));
    compare_field("ack_error", 32'(got.err), 32'(w.err));
    compare_field("read_word", got.word, w.word);
    results_seen++;
  endtask
endclass

module tb_i2c_sensor_transaction_master_core;

  localparam int HalfPeriod = 5;
  localparam int LongHold   = 60;
  localparam int RunLimit   = 5_000_000;

  // How the sensor side answers on SDA during the current transfer.
  typedef enum {SDA_RANDOM, SDA_LOW, SDA_MOSTLY_HIGH, SDA_HIGH} sda_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  // tick channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  i2cstm_pkg::func_e tick_func = i2cstm_pkg::FUNC_TICK;
  logic [7:0]  first_byte = '0;
  logic [7:0]  second_byte = '0;
  logic        sda_in = 1'b1;

  // result channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        sda_drv;
  logic        busy;
  logic        done;
  logic        ack_err;
  logic [31:0] rd_word;

  // configuration channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  i2cstm_pkg::cfg_index_e cfg_index = i2cstm_pkg::CFG_DEV_ADDR;
  logic [19:0] cfg_data = '0;

  sensor_bus_scoreboard sb = new();

  sda_mode_e   sda_mode = SDA_RANDOM;
  int          burst_left = 0;
  bit          offering = 1'b0;
  bit          hold_req = 1'b0;

  always #(HalfPeriod) clk = ~clk;

  i2c_sensor_transaction_master_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (tick_func),
    .cmd_first_byte_i  (first_byte),
    .cmd_second_byte_i (second_byte),
    .sda_sample_i      (sda_in),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .scl_level_o       (scl_lvl),
    .sda_level_o       (sda_lvl),
    .sda_driving_o     (sda_drv),
    .busy_res_o        (busy),
    .done_res_o        (done),
    .ack_error_o       (ack_err),
    .read_word_o       (rd_word),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  // Compare every result transfer with the oldest predicted tick.
  always @(posedge clk) begin : result_check
    bus_view_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{scl: scl_lvl, sda: sda_lvl, drive: sda_drv, busy: busy, done: done,
              err: ack_err, word: rd_word};
      sb.check_result(got);
    end
  end

  // Stall the result side on its own pattern: spans of random stall density,
  // some with no stalls at all, plus one long hold-off on request.
  initial begin : result_sink
    int stall_pct;
    int span;
    @(posedge rst_n);
    forever begin
      span      = $urandom_range(16, 96);
      stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (LongHold) @(posedge clk);
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one tick and hold it until the transfer; then feed the predictor.
  task automatic send_tick(bus_tick_t t);
    in_valid    <= 1'b1;
    offering     = 1'b1;
    tick_func   <= t.func;
    first_byte  <= t.first;
    second_byte <= t.second;
    sda_in      <= t.sda;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  // Drop valid for a random gap, possibly none, whenever the current burst runs out.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      case ($urandom_range(7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0 && offering) begin
        in_valid <= 1'b0;
        offering  = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    burst_left--;
  endtask

  // Hold off the tick side until every predicted result has been taken.
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(i2cstm_pkg::cfg_index_e idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(logic [6:0] addr, logic [15:0] phase, logic [7:0] tmo,
                           logic [19:0] post);
    settle();
    write_reg(i2cstm_pkg::CFG_DEV_ADDR, {13'd0, addr});
    write_reg(i2cstm_pkg::CFG_PHASE, {4'd0, phase});
    write_reg(i2cstm_pkg::CFG_ACK_TMO, {12'd0, tmo});
    write_reg(i2cstm_pkg::CFG_POST_WRITE, post);
    cfg_valid <= 1'b0;
  endtask

  // Build the next tick from the predicted sequencer state: commands mostly
  // land on idle ticks, noise commands while busy must be ignored.
  function automatic bus_tick_t next_tick(bit allow_cmd, bit allow_write);
    bus_tick_t t;
    int        pick;
    t.first  = 8'($urandom_range(255));
    t.second = 8'($urandom_range(255));
    pick     = $urandom_range(9);
    if (sb.seq == i2cstm_pkg::ST_IDLE && allow_cmd && pick < 3) begin
      t.func = (allow_write && $urandom_range(1) == 1) ? i2cstm_pkg::FUNC_WRITE
                                                       : i2cstm_pkg::FUNC_READ;
      pick   = $urandom_range(9);
      if (pick < 5)      sda_mode = SDA_RANDOM;
      else if (pick < 7) sda_mode = SDA_LOW;
      else if (pick < 9) sda_mode = SDA_MOSTLY_HIGH;
      else               sda_mode = SDA_HIGH;
    end else if (sb.seq == i2cstm_pkg::ST_IDLE) begin
      t.func = (pick < 7) ? i2cstm_pkg::FUNC_TICK : i2cstm_pkg::FUNC_RSVD;
    end else begin
      t.func = (pick < 7) ? i2cstm_pkg::FUNC_TICK : i2cstm_pkg::func_e'($urandom_range(3));
    end
    case (sda_mode)
      SDA_LOW:         t.sda = 1'b0;
      SDA_MOSTLY_HIGH: t.sda = ($urandom_range(15) != 0);
      SDA_HIGH:        t.sda = 1'b1;
      default:         t.sda = 1'($urandom_range(1));
    endcase
    return t;
  endfunction

  // Run plain ticks until the sequencer is back at idle.
  task automatic finish_transfer();
    while (sb.seq != i2cstm_pkg::ST_IDLE) begin
      pace();
      send_tick(next_tick(1'b0, 1'b0));
    end
  endtask

  task automatic random_ticks(int n, bit allow_cmd, bit allow_write, int hold_at,
                              int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) settle();
      pace();
      send_tick(next_tick(allow_cmd, allow_write));
    end
    finish_transfer();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks at the reset configuration: both lines rest high
    send_tick('{i2cstm_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0});
    send_tick('{i2cstm_pkg::FUNC_RSVD, 8'hFF, 8'hFF, 1'b1});
    send_tick('{i2cstm_pkg::FUNC_RSVD, 8'h00, 8'hFF, 1'b0});

    // short phases, immediate acknowledge timeout, no wait after a write
    configure(7'd0, 16'd2, 8'd0, 20'd0);
    sda_mode = SDA_LOW;
    send_tick('{i2cstm_pkg::FUNC_WRITE, 8'hFF, 8'h00, 1'b0});
    // commands while busy and the reserved code are plain ticks
    send_tick('{i2cstm_pkg::FUNC_READ, 8'h00, 8'hFF, 1'b1});
    send_tick('{i2cstm_pkg::FUNC_RSVD, 8'hA5, 8'h5A, 1'b0});
    send_tick('{i2cstm_pkg::FUNC_WRITE, 8'h5A, 8'hA5, 1'b1});
    finish_transfer();
    // address never acknowledged: STOP with the error flag
    sda_mode = SDA_HIGH;
    send_tick('{i2cstm_pkg::FUNC_READ, 8'hFF, 8'hFF, 1'b1});
    finish_transfer();
    // a read with random SDA bits, which may end at the address acknowledge
    sda_mode = SDA_RANDOM;
    send_tick('{i2cstm_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0});
    finish_transfer();
    random_ticks(70, 1'b1, 1'b1, -1, -1);

    // one-tick phases, longest acknowledge window; hold off results midway
    configure(7'd127, 16'd1, 8'd255, 20'd1);
    random_ticks(110, 1'b1, 1'b1, 30, -1);

    // zero-length phases
    configure(7'($urandom_range(127)), 16'd0, 8'd3, 20'd5);
    random_ticks(70, 1'b1, 1'b1, -1, -1);

    // pause the tick side midway until every result has come back
    configure(7'($urandom_range(127)), 16'd3, 8'd1, 20'd0);
    random_ticks(80, 1'b1, 1'b1, -1, 40);

    // longest post-write wait: reads only so the run stays short
    configure(7'($urandom_range(127)), 16'd2, 8'd6, 20'hFFFFF);
    random_ticks(60, 1'b1, 1'b0, -1, -1);

    // longest phase: idle ticks only
    configure(7'($urandom_range(127)), 16'hFFFF, 8'd255, 20'hFFFFF);
    random_ticks(20, 1'b0, 1'b0, -1, -1);

    configure(7'($urandom_range(127)), 16'd2, 8'd10, 20'd40);
    random_ticks(60, 1'b1, 1'b1, -1, -1);

    // drain, then wait for any stray result
    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimit);
    $display("TB_ERROR");
    $finish;
  end

endmodule
